// ===== hw/rtl/lgrf_pkg.sv =====
// Shared types and constants for the linear Gaussian regression fit core.
// No dependencies; imported by every module of the block.
package lgrf_pkg;

	localparam int MAX_ROWS_DEF    = 65536;
	localparam int SAMPLE_BITS_DEF = 24;

	// widths of the running sums (fixed by the largest data set)
	localparam int CNT_W  = 17;
	localparam int LSUM_W = 48;
	localparam int QSUM_W = 64;

	localparam int OUT_W = 64;
	localparam int VAR_W = 63;

	// row queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_SING = 2'd2
	} fit_status_t;

	typedef struct packed {
		logic [CNT_W-1:0]         n;
		logic signed [LSUM_W-1:0] sy;
		logic signed [LSUM_W-1:0] s1;
		logic signed [LSUM_W-1:0] s2;
		logic signed [QSUM_W-1:0] qyy;
		logic signed [QSUM_W-1:0] q11;
		logic signed [QSUM_W-1:0] q22;
		logic signed [QSUM_W-1:0] q12;
		logic signed [QSUM_W-1:0] qy1;
		logic signed [QSUM_W-1:0] qy2;
	} sums_t;

	typedef struct packed {
		logic [OUT_W-1:0] intercept;
		logic [OUT_W-1:0] slope_first;
		logic [OUT_W-1:0] slope_second;
		logic [VAR_W-1:0] variance;
		fit_status_t      status;
	} fit_t;

endpackage

// ===== hw/rtl/lgrf_front.sv =====
// Front end: takes rows from the push side, drops rows that carry nothing,
// and queues the rest for the accumulator. Depends on lgrf_pkg.
module lgrf_front import lgrf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] resp_in,
	input  logic signed [SAMPLE_BITS-1:0] p1_in,
	input  logic signed [SAMPLE_BITS-1:0] p2_in,
	input  logic                          complete_in,
	input  logic                          last_in,
	output logic                          q_valid,
	input  logic                          q_pop,
	output logic signed [SAMPLE_BITS-1:0] q_resp,
	output logic signed [SAMPLE_BITS-1:0] q_p1,
	output logic signed [SAMPLE_BITS-1:0] q_p2,
	output logic                          q_complete,
	output logic                          q_last
);

	logic signed [SAMPLE_BITS-1:0] resp_q [QDEPTH];
	logic signed [SAMPLE_BITS-1:0] p1_q [QDEPTH];
	logic signed [SAMPLE_BITS-1:0] p2_q [QDEPTH];
	logic                          complete_q [QDEPTH];
	logic                          last_q [QDEPTH];
	logic [QPTR_W-1:0]             wptr_q, rptr_q;
	logic [QPTR_W:0]               count_q;
	logic                          wr, rd;

	assign full = (count_q == (QPTR_W+1)'(QDEPTH));
	// an incomplete row that is not the last one changes nothing: drop it
	assign wr = push && !full && (complete_in || last_in);
	assign rd = q_pop && q_valid;

	assign q_valid    = (count_q != '0);
	assign q_resp     = resp_q[rptr_q];
	assign q_p1       = p1_q[rptr_q];
	assign q_p2       = p2_q[rptr_q];
	assign q_complete = complete_q[rptr_q];
	assign q_last     = last_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			resp_q[wptr_q]     <= resp_in;
			p1_q[wptr_q]       <= p1_in;
			p2_q[wptr_q]       <= p2_in;
			complete_q[wptr_q] <= complete_in;
			last_q[wptr_q]     <= last_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (rd)
				rptr_q <= rptr_q + 1'b1;
			if (wr && !rd)
				count_q <= count_q + 1'b1;
			else if (!wr && rd)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/lgrf_accum.sv =====
// Back end accumulator: squares and cross-products of each complete row are
// summed up to MAX_ROWS rows; a last row raises a fit request and holds the sums. Uses lgrf_pkg.
module lgrf_accum import lgrf_pkg::*; #(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic signed [SAMPLE_BITS-1:0] q_resp,
	input  logic signed [SAMPLE_BITS-1:0] q_p1,
	input  logic signed [SAMPLE_BITS-1:0] q_p2,
	input  logic                          q_complete,
	input  logic                          q_last,
	input  logic                          taken,
	output logic                          fit_req,
	output sums_t                         sums
);

	localparam int PW = 2 * SAMPLE_BITS;

	logic                          en;
	logic                          valid_s1, valid_s2;
	logic                          complete_s1, complete_s2, last_s1, last_s2;
	logic signed [SAMPLE_BITS-1:0] y_s1, x1_s1, x2_s1;
	logic signed [SAMPLE_BITS-1:0] y_s2, x1_s2, x2_s2;
	logic signed [PW-1:0]          pyy_s2, p11_s2, p22_s2, p12_s2, py1_s2, py2_s2;
	logic                          fit_pend_q;
	logic                          add;
	sums_t                         sums_q;

	// the whole pipe holds while a finished data set waits for the solver
	assign en      = !fit_pend_q;
	assign q_pop   = q_valid && en;
	assign fit_req = fit_pend_q;
	assign sums    = sums_q;
	assign add     = en && valid_s2 && complete_s2 && (sums_q.n < CNT_W'(MAX_ROWS));

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1        <= q_resp;
			x1_s1       <= q_p1;
			x2_s1       <= q_p2;
			complete_s1 <= q_complete;
			last_s1     <= q_last;
			y_s2        <= y_s1;
			x1_s2       <= x1_s1;
			x2_s2       <= x2_s1;
			complete_s2 <= complete_s1;
			last_s2     <= last_s1;
			pyy_s2      <= y_s1 * y_s1;
			p11_s2      <= x1_s1 * x1_s1;
			p22_s2      <= x2_s1 * x2_s1;
			p12_s2      <= x1_s1 * x2_s1;
			py1_s2      <= y_s1 * x1_s1;
			py2_s2      <= y_s1 * x2_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			fit_pend_q <= 1'b0;
			sums_q     <= '0;
		end else begin
			if (en) begin
				valid_s1 <= q_valid;
				valid_s2 <= valid_s1;
			end
			if (taken) begin
				fit_pend_q <= 1'b0;
				sums_q     <= '0;
			end else begin
				if (add) begin
					sums_q.n   <= sums_q.n + 1'b1;
					sums_q.sy  <= sums_q.sy + LSUM_W'(y_s2);
					sums_q.s1  <= sums_q.s1 + LSUM_W'(x1_s2);
					sums_q.s2  <= sums_q.s2 + LSUM_W'(x2_s2);
					sums_q.qyy <= sums_q.qyy + QSUM_W'(pyy_s2);
					sums_q.q11 <= sums_q.q11 + QSUM_W'(p11_s2);
					sums_q.q22 <= sums_q.q22 + QSUM_W'(p22_s2);
					sums_q.q12 <= sums_q.q12 + QSUM_W'(p12_s2);
					sums_q.qy1 <= sums_q.qy1 + QSUM_W'(py1_s2);
					sums_q.qy2 <= sums_q.qy2 + QSUM_W'(py2_s2);
				end
				if (en && valid_s2 && last_s2)
					fit_pend_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/lgrf_solver.sv =====
// Fit solver: a small microcoded sequencer over a 256-bit register file with
// a shift-add multiplier and a restoring rounding divider. Uses lgrf_pkg.
module lgrf_solver import lgrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] parent_count,
	input  logic       fit_req,
	input  sums_t      sums,
	output logic       taken,
	input  logic       out_free,
	output logic       res_valid,
	output fit_t       res
);

	localparam int BW     = 256;
	localparam int IT_W   = $clog2(BW);
	localparam int RF_AW  = 5;
	localparam int RF_N   = 32;
	localparam int PC_W   = 7;
	localparam logic [IT_W-1:0] IT_LAST = IT_W'(BW - 1);

	// register file map; entries up to R_K are loaded at start from the sums and constants
	localparam logic [RF_AW-1:0] R_N = 5'd0, R_SY = 5'd1, R_S1 = 5'd2, R_S2 = 5'd3;
	localparam logic [RF_AW-1:0] R_QYY = 5'd4, R_Q11 = 5'd5, R_Q22 = 5'd6, R_Q12 = 5'd7;
	localparam logic [RF_AW-1:0] R_QY1 = 5'd8, R_QY2 = 5'd9, R_T16 = 5'd10, R_T32 = 5'd11;
	localparam logic [RF_AW-1:0] R_K = 5'd12, R_CYY = 5'd13, R_C11 = 5'd14, R_C22 = 5'd15;
	localparam logic [RF_AW-1:0] R_C12 = 5'd16, R_CY1 = 5'd17, R_CY2 = 5'd18, R_DEN = 5'd19;
	localparam logic [RF_AW-1:0] R_N1 = 5'd20, R_N2 = 5'd21, R_AN = 5'd22, R_VN = 5'd23;
	localparam logic [RF_AW-1:0] R_ND = 5'd24, R_TA = 5'd25, R_TB = 5'd26;

	// output slots for the OUT op
	localparam logic [RF_AW-1:0] O_INT = 5'd0, O_SL1 = 5'd1, O_SL2 = 5'd2, O_VAR = 5'd3;

	localparam logic [PC_W-1:0] PC_P0 = 7'd19, PC_P1 = 7'd26, PC_P2 = 7'd44;

	typedef enum logic [2:0] {
		OP_MUL, OP_SUB, OP_DIV, OP_CHKZ, OP_OUT, OP_BRP, OP_END
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [RF_AW-1:0] d;
		logic [RF_AW-1:0] a;
		logic [RF_AW-1:0] b;
	} instr_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_INIT = 9'b000000010,
		S_RDA  = 9'b000000100,
		S_RDB  = 9'b000001000,
		S_EXEC = 9'b000010000,
		S_MUL  = 9'b000100000,
		S_DIV  = 9'b001000000,
		S_WB   = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	function automatic instr_t mk(input op_t op, input logic [RF_AW-1:0] d,
		input logic [RF_AW-1:0] a, input logic [RF_AW-1:0] b);
		instr_t r;
		r.op = op;
		r.d  = d;
		r.a  = a;
		r.b  = b;
		return r;
	endfunction

	function automatic instr_t rom(input logic [PC_W-1:0] pc);
		instr_t r;
		unique case (pc)
			// centered sums, C = n*Sab - Sa*Sb
			7'd0:  r = mk(OP_MUL, R_TA, R_N, R_QYY);
			7'd1:  r = mk(OP_MUL, R_TB, R_SY, R_SY);
			7'd2:  r = mk(OP_SUB, R_CYY, R_TA, R_TB);
			7'd3:  r = mk(OP_MUL, R_TA, R_N, R_Q11);
			7'd4:  r = mk(OP_MUL, R_TB, R_S1, R_S1);
			7'd5:  r = mk(OP_SUB, R_C11, R_TA, R_TB);
			7'd6:  r = mk(OP_MUL, R_TA, R_N, R_Q22);
			7'd7:  r = mk(OP_MUL, R_TB, R_S2, R_S2);
			7'd8:  r = mk(OP_SUB, R_C22, R_TA, R_TB);
			7'd9:  r = mk(OP_MUL, R_TA, R_N, R_Q12);
			7'd10: r = mk(OP_MUL, R_TB, R_S1, R_S2);
			7'd11: r = mk(OP_SUB, R_C12, R_TA, R_TB);
			7'd12: r = mk(OP_MUL, R_TA, R_N, R_QY1);
			7'd13: r = mk(OP_MUL, R_TB, R_SY, R_S1);
			7'd14: r = mk(OP_SUB, R_CY1, R_TA, R_TB);
			7'd15: r = mk(OP_MUL, R_TA, R_N, R_QY2);
			7'd16: r = mk(OP_MUL, R_TB, R_SY, R_S2);
			7'd17: r = mk(OP_SUB, R_CY2, R_TA, R_TB);
			7'd18: r = mk(OP_BRP, R_TA, R_TA, R_TA);
			// mean only
			7'd19: r = mk(OP_MUL, R_TA, R_SY, R_T16);
			7'd20: r = mk(OP_DIV, R_TA, R_TA, R_N);
			7'd21: r = mk(OP_OUT, O_INT, R_TA, R_TA);
			7'd22: r = mk(OP_MUL, R_TB, R_N, R_K);
			7'd23: r = mk(OP_DIV, R_TA, R_CYY, R_TB);
			7'd24: r = mk(OP_OUT, O_VAR, R_TA, R_TA);
			7'd25: r = mk(OP_END, R_TA, R_TA, R_TA);
			// one parent
			7'd26: r = mk(OP_CHKZ, R_TA, R_C11, R_TA);
			7'd27: r = mk(OP_MUL, R_TA, R_CY1, R_T32);
			7'd28: r = mk(OP_DIV, R_TA, R_TA, R_C11);
			7'd29: r = mk(OP_OUT, O_SL1, R_TA, R_TA);
			7'd30: r = mk(OP_MUL, R_TA, R_SY, R_C11);
			7'd31: r = mk(OP_MUL, R_TB, R_CY1, R_S1);
			7'd32: r = mk(OP_SUB, R_AN, R_TA, R_TB);
			7'd33: r = mk(OP_MUL, R_ND, R_N, R_C11);
			7'd34: r = mk(OP_MUL, R_TA, R_AN, R_T16);
			7'd35: r = mk(OP_DIV, R_TA, R_TA, R_ND);
			7'd36: r = mk(OP_OUT, O_INT, R_TA, R_TA);
			7'd37: r = mk(OP_MUL, R_TA, R_CYY, R_C11);
			7'd38: r = mk(OP_MUL, R_TB, R_CY1, R_CY1);
			7'd39: r = mk(OP_SUB, R_VN, R_TA, R_TB);
			7'd40: r = mk(OP_MUL, R_TB, R_ND, R_K);
			7'd41: r = mk(OP_DIV, R_TA, R_VN, R_TB);
			7'd42: r = mk(OP_OUT, O_VAR, R_TA, R_TA);
			7'd43: r = mk(OP_END, R_TA, R_TA, R_TA);
			// two parents
			7'd44: r = mk(OP_MUL, R_TA, R_C11, R_C22);
			7'd45: r = mk(OP_MUL, R_TB, R_C12, R_C12);
			7'd46: r = mk(OP_SUB, R_DEN, R_TA, R_TB);
			7'd47: r = mk(OP_CHKZ, R_TA, R_DEN, R_TA);
			7'd48: r = mk(OP_MUL, R_TA, R_C22, R_CY1);
			7'd49: r = mk(OP_MUL, R_TB, R_C12, R_CY2);
			7'd50: r = mk(OP_SUB, R_N1, R_TA, R_TB);
			7'd51: r = mk(OP_MUL, R_TA, R_C11, R_CY2);
			7'd52: r = mk(OP_MUL, R_TB, R_C12, R_CY1);
			7'd53: r = mk(OP_SUB, R_N2, R_TA, R_TB);
			7'd54: r = mk(OP_MUL, R_TA, R_N1, R_T32);
			7'd55: r = mk(OP_DIV, R_TA, R_TA, R_DEN);
			7'd56: r = mk(OP_OUT, O_SL1, R_TA, R_TA);
			7'd57: r = mk(OP_MUL, R_TA, R_N2, R_T32);
			7'd58: r = mk(OP_DIV, R_TA, R_TA, R_DEN);
			7'd59: r = mk(OP_OUT, O_SL2, R_TA, R_TA);
			7'd60: r = mk(OP_MUL, R_TA, R_SY, R_DEN);
			7'd61: r = mk(OP_MUL, R_TB, R_N1, R_S1);
			7'd62: r = mk(OP_SUB, R_AN, R_TA, R_TB);
			7'd63: r = mk(OP_MUL, R_TB, R_N2, R_S2);
			7'd64: r = mk(OP_SUB, R_AN, R_AN, R_TB);
			7'd65: r = mk(OP_MUL, R_ND, R_N, R_DEN);
			7'd66: r = mk(OP_MUL, R_TA, R_AN, R_T16);
			7'd67: r = mk(OP_DIV, R_TA, R_TA, R_ND);
			7'd68: r = mk(OP_OUT, O_INT, R_TA, R_TA);
			7'd69: r = mk(OP_MUL, R_TA, R_CYY, R_DEN);
			7'd70: r = mk(OP_MUL, R_TB, R_N1, R_CY1);
			7'd71: r = mk(OP_SUB, R_VN, R_TA, R_TB);
			7'd72: r = mk(OP_MUL, R_TB, R_N2, R_CY2);
			7'd73: r = mk(OP_SUB, R_VN, R_VN, R_TB);
			7'd74: r = mk(OP_MUL, R_TB, R_ND, R_K);
			7'd75: r = mk(OP_DIV, R_TA, R_VN, R_TB);
			7'd76: r = mk(OP_OUT, O_VAR, R_TA, R_TA);
			default: r = mk(OP_END, R_TA, R_TA, R_TA);
		endcase
		return r;
	endfunction

	function automatic logic [OUT_W-1:0] sat64(input logic [BW-1:0] v);
		logic [BW-OUT_W:0] hi;
		logic [OUT_W-1:0]  r;
		hi = v[BW-1:OUT_W-1];
		if ((&hi) || !(|hi))
			r = v[OUT_W-1:0];
		else if (v[BW-1])
			r = {1'b1, {(OUT_W-1){1'b0}}};
		else
			r = {1'b0, {(OUT_W-1){1'b1}}};
		return r;
	endfunction

	state_t           state_q;
	logic [PC_W-1:0]  pc_q;
	logic [IT_W-1:0]  cnt_q;
	logic [1:0]       p_q;
	logic [1:0]       p_now;
	logic [BW-1:0]    rf [RF_N];
	logic [BW-1:0]    rd_q, opa_q;
	logic [BW-1:0]    acc_q, x_q, y_q, rem_q;
	logic             neg_q;
	fit_t             res_q;
	instr_t           ins;
	logic [RF_AW-1:0] rd_addr;
	logic             we;
	logic [RF_AW-1:0] waddr;
	logic [BW-1:0]    wdata;
	logic [BW-1:0]    init_val, ma, mb, diff, wb_val, rem_sh;
	logic [OUT_W-1:0] sat_a;
	logic             rem_ge, few;

	assign ins       = rom(pc_q);
	assign p_now     = (parent_count == 2'd3) ? 2'd2 : parent_count;
	assign few       = (sums.n < (CNT_W'(p_now) + CNT_W'(2)));
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	assign ma     = opa_q[BW-1] ? (~opa_q + 1'b1) : opa_q;
	assign mb     = rd_q[BW-1] ? (~rd_q + 1'b1) : rd_q;
	assign diff   = opa_q - rd_q;
	assign wb_val = (ins.op == OP_MUL) ? acc_q : x_q;
	assign rem_sh = {rem_q[BW-2:0], x_q[BW-1]};
	assign rem_ge = (rem_sh >= y_q);
	assign sat_a  = sat64(opa_q);

	always_comb begin
		unique case (cnt_q[RF_AW-1:0])
			R_N:     init_val = BW'(sums.n);
			R_SY:    init_val = {{(BW-LSUM_W){sums.sy[LSUM_W-1]}}, sums.sy};
			R_S1:    init_val = {{(BW-LSUM_W){sums.s1[LSUM_W-1]}}, sums.s1};
			R_S2:    init_val = {{(BW-LSUM_W){sums.s2[LSUM_W-1]}}, sums.s2};
			R_QYY:   init_val = {{(BW-QSUM_W){sums.qyy[QSUM_W-1]}}, sums.qyy};
			R_Q11:   init_val = {{(BW-QSUM_W){sums.q11[QSUM_W-1]}}, sums.q11};
			R_Q22:   init_val = {{(BW-QSUM_W){sums.q22[QSUM_W-1]}}, sums.q22};
			R_Q12:   init_val = {{(BW-QSUM_W){sums.q12[QSUM_W-1]}}, sums.q12};
			R_QY1:   init_val = {{(BW-QSUM_W){sums.qy1[QSUM_W-1]}}, sums.qy1};
			R_QY2:   init_val = {{(BW-QSUM_W){sums.qy2[QSUM_W-1]}}, sums.qy2};
			R_T16:   init_val = BW'(1) << 16;
			R_T32:   init_val = BW'(1) << 32;
			// degrees of freedom n - p - 1
			R_K:     init_val = BW'(sums.n) - BW'(p_q) - BW'(1);
			default: init_val = '0;
		endcase
	end

	always_comb begin
		rd_addr = (state_q == S_RDB) ? ins.b : ins.a;
		we      = 1'b0;
		waddr   = ins.d;
		wdata   = diff;
		taken   = 1'b0;
		unique case (state_q)
			S_IDLE: taken = fit_req && few;
			S_INIT: begin
				we    = 1'b1;
				waddr = cnt_q[RF_AW-1:0];
				wdata = init_val;
				taken = (cnt_q[RF_AW-1:0] == R_K);
			end
			S_EXEC: begin
				if (ins.op == OP_SUB) begin
					we = 1'b1;
				end else if (ins.op == OP_DIV && mb == '0) begin
					we    = 1'b1;
					wdata = '0;
				end
			end
			S_WB: begin
				we    = 1'b1;
				wdata = neg_q ? (~wb_val + 1'b1) : wb_val;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			rf[waddr] <= wdata;
		rd_q <= rf[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_RDB: opa_q <= rd_q;
			S_EXEC: begin
				acc_q <= '0;
				rem_q <= '0;
				neg_q <= opa_q[BW-1] ^ rd_q[BW-1];
				if (ins.op == OP_MUL) begin
					x_q <= ma;
					y_q <= mb;
				end else begin
					// round to nearest, ties away: (2|a| + |d|) / 2|d|
					x_q <= (ma << 1) + mb;
					y_q <= mb << 1;
				end
			end
			S_MUL: begin
				if (y_q[0])
					acc_q <= acc_q + x_q;
				x_q <= x_q << 1;
				y_q <= y_q >> 1;
			end
			S_DIV: begin
				rem_q <= rem_ge ? (rem_sh - y_q) : rem_sh;
				x_q   <= {x_q[BW-2:0], rem_ge};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			cnt_q   <= '0;
			p_q     <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (fit_req) begin
						res_q <= '{intercept: '0, slope_first: '0, slope_second: '0,
							variance: '0, status: (few ? ST_FEW : ST_OK)};
						p_q   <= p_now;
						cnt_q <= '0;
						if (few)
							state_q <= S_DONE;
						else
							state_q <= S_INIT;
					end
				end
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[RF_AW-1:0] == R_K) begin
						pc_q    <= '0;
						state_q <= S_RDA;
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_EXEC;
				S_EXEC: begin
					cnt_q <= '0;
					unique case (ins.op)
						OP_MUL: state_q <= S_MUL;
						OP_DIV: begin
							if (mb == '0) begin
								pc_q    <= pc_q + 1'b1;
								state_q <= S_RDA;
							end else begin
								state_q <= S_DIV;
							end
						end
						OP_SUB: begin
							pc_q    <= pc_q + 1'b1;
							state_q <= S_RDA;
						end
						OP_CHKZ: begin
							if (opa_q == '0) begin
								res_q   <= '{intercept: '0, slope_first: '0, slope_second: '0,
									variance: '0, status: ST_SING};
								state_q <= S_DONE;
							end else begin
								pc_q    <= pc_q + 1'b1;
								state_q <= S_RDA;
							end
						end
						OP_OUT: begin
							unique case (ins.d)
								O_INT: res_q.intercept    <= sat_a;
								O_SL1: res_q.slope_first  <= sat_a;
								O_SL2: res_q.slope_second <= sat_a;
								default: begin
									// a negative variance reads as zero
									if (opa_q[BW-1])
										res_q.variance <= '0;
									else
										res_q.variance <= sat_a[VAR_W-1:0];
								end
							endcase
							pc_q    <= pc_q + 1'b1;
							state_q <= S_RDA;
						end
						OP_BRP: begin
							if (p_q == 2'd0)
								pc_q <= PC_P0;
							else if (p_q == 2'd1)
								pc_q <= PC_P1;
							else
								pc_q <= PC_P2;
							state_q <= S_RDA;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_MUL, S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IT_LAST)
						state_q <= S_WB;
				end
				S_WB: begin
					pc_q    <= pc_q + 1'b1;
					state_q <= S_RDA;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/linear_gaussian_regression_fit_core.sv =====
// Top level of the linear Gaussian regression fit core: row queue, accumulator,
// solver and result register. Depends on lgrf_pkg and the lgrf_* modules.
//
// Rows enter through push/full: a word is taken at a clock edge with push high
// and full low. Incomplete rows that are not last are taken and dropped.
// Complete rows go through a four-word queue and a two-stage multiply and
// accumulate pipe at one row per cycle while no finished set waits for the solver.
// The row marked last closes the data set: the sums are copied into the solver
// and cleared, and rows of the next set stream on while it solves.
// The solver runs each wide product and each rounding division one bit per
// cycle over 256 bits. With too few rows it skips the arithmetic and goes
// straight to a result with status ST_FEW.
// Results leave through empty/pop from a one-word output register; while it is
// full the solver holds its finished result, and after that the row side fills
// up and full rises. parent_count is written through cfg_valid/cfg_ready
// (ready is always high) and must only change while the block is idle.
// Reset (arst_n low) clears the sums, the queue, the result and parent_count.
module linear_gaussian_regression_fit_core import lgrf_pkg::*; #(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] response_sample,
	input  logic signed [SAMPLE_BITS-1:0] parent1_sample,
	input  logic signed [SAMPLE_BITS-1:0] parent2_sample,
	input  logic                          row_complete,
	input  logic                          last_row,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [OUT_W-1:0]       intercept,
	output logic signed [OUT_W-1:0]       slope_first,
	output logic signed [OUT_W-1:0]       slope_second,
	output logic [VAR_W-1:0]              residual_variance,
	output logic [1:0]                    fit_status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    parent_count
);

	logic                          q_valid, q_pop, q_complete, q_last;
	logic signed [SAMPLE_BITS-1:0] q_resp, q_p1, q_p2;
	logic                          taken, fit_req, res_valid, out_free;
	sums_t                         sums;
	fit_t                          res, out_q;
	logic                          out_valid_q;
	logic [1:0]                    parent_count_q;

	lgrf_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.resp_in    (response_sample),
		.p1_in      (parent1_sample),
		.p2_in      (parent2_sample),
		.complete_in(row_complete),
		.last_in    (last_row),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_resp     (q_resp),
		.q_p1       (q_p1),
		.q_p2       (q_p2),
		.q_complete (q_complete),
		.q_last     (q_last)
	);

	lgrf_accum #(
		.MAX_ROWS   (MAX_ROWS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_resp    (q_resp),
		.q_p1      (q_p1),
		.q_p2      (q_p2),
		.q_complete(q_complete),
		.q_last    (q_last),
		.taken     (taken),
		.fit_req   (fit_req),
		.sums      (sums)
	);

	lgrf_solver u_solver (
		.clk         (clk),
		.arst_n      (arst_n),
		.parent_count(parent_count_q),
		.fit_req     (fit_req),
		.sums        (sums),
		.taken       (taken),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res         (res)
	);

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || pop;
	assign empty     = !out_valid_q;

	assign intercept         = out_q.intercept;
	assign slope_first       = out_q.slope_first;
	assign slope_second      = out_q.slope_second;
	assign residual_variance = out_q.variance;
	assign fit_status        = out_q.status;

	always_ff @(posedge clk) begin
		if (res_valid && out_free)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			parent_count_q <= '0;
		end else begin
			if (res_valid && out_free)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (cfg_valid)
				parent_count_q <= parent_count;
		end
	end

endmodule
